@@ hdl/tce_pkg.sv @@
// Shared constants, command codes and the sequencer state type of the text console.
// No dependencies; imported by text_console_engine and the testbench.
package tce_pkg;

	// Screen geometry and derived widths
	localparam int COLS   = 80;
	localparam int ROWS   = 25;
	localparam int NCELLS = COLS * ROWS;
	localparam int COL_W  = 7;
	localparam int ROW_W  = 5;
	localparam int ADDR_W = $clog2(NCELLS);
	localparam int CLR_W  = 4;

	// Cell content after reset: character 0, white on black
	localparam logic [15:0] RESET_CELL = 16'h0F00;

	// Control characters
	localparam logic [7:0] CHAR_NL  = 8'd10;
	localparam logic [7:0] CHAR_TAB = 8'd9;

	// Command codes
	typedef enum logic [2:0] {
		CMD_PUT    = 3'd0,
		CMD_SETCUR = 3'd1,
		CMD_CLRSCR = 3'd2,
		CMD_CLRLN  = 3'd3,
		CMD_SCROLL = 3'd4,
		CMD_READ   = 3'd5,
		CMD_NOP6   = 3'd6,
		CMD_NOP7   = 3'd7
	} cmd_t;

	// Configuration register indexes
	localparam logic CFG_TEXT_COLOR = 1'b0;
	localparam logic CFG_BACK_COLOR = 1'b1;

	// Sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_TAB2  = 5'b00100,
		ST_SWEEP = 5'b01000,
		ST_DONE  = 5'b10000
	} state_t;

	// Linear cell address of a row and column
	function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
		input logic [COL_W-1:0] c);
		cell_addr = ADDR_W'(r) * ADDR_W'(COLS) + ADDR_W'(c);
	endfunction

endpackage

@@ hdl/text_console_engine.sv @@
// Text console engine: cell store in one synchronous RAM, cursor and command sequencer.
// Depends on tce_pkg (geometry, command codes, state type).
//
//   channel   dir  handshake            contents
//   s_*       in   s_tvalid / s_tready  request: command (tuser), char, col, row, line arg
//   m_*       out  m_tvalid / m_tready  result: cursor col, row, offset, cell char, attr
//   cfg_*     in   cfg_we               color register writes, no read-back
//
// Set cursor, read cell, plain char, newline and unused codes finish in the execute state;
// a tab adds a second write state. Clear line sweeps 80 cells, and clear screen, scroll and a put char
// that runs off the bottom row sweep all 2000 cells at one write per cycle, since the cell RAM
// has a single write port.
// After reset a clearing pass fills all 2000 cells of the RAM, with s_tready low throughout.
// A stalled result waits in the output register; the next request can still be accepted.
module text_console_engine (
	input  logic        clk,
	input  logic        arst_n,
	// Request stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // char_code[7:0], col[14:8], row[19:15], line_arg[24:20]
	input  logic [2:0]  s_tuser,   // command[2:0]
	// Result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
	                               // cell_char[30:23], cell_attr[38:31]
	// Configuration
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data
);
	import tce_pkg::*;

	localparam logic [ADDR_W-1:0] END_ADDR  = ADDR_W'(NCELLS);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NCELLS - 1);

	// Cell RAM
	logic [15:0]       mem [NCELLS];
	logic [15:0]       rd_q;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [15:0]       wr_data;

	// Control and cursor state
	state_t            state_q, state_d;
	logic [COL_W-1:0]  cur_col_q, cur_col_d;
	logic [ROW_W-1:0]  cur_row_q, cur_row_d;
	logic [CLR_W-1:0]  text_q, back_q;
	logic [ADDR_W-1:0] src_q, src_d, dst_q, dst_d, end_q, end_d;
	logic [ADDR_W-1:0] tab_addr_q, tab_addr_d;
	logic              pend_s1, pend_d;
	logic              init_q, init_d;
	logic              scroll_q, scroll_d;
	logic [15:0]       cell_q, cell_d;
	logic              m_tvalid_q;
	logic [39:0]       m_tdata_q;

	// Captured request
	cmd_t              cmd_q;
	logic [7:0]        char_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [ROW_W-1:0]  arg_q;

	// Request decode and clamp
	logic              accept;
	logic [COL_W-1:0]  in_col;
	logic [ROW_W-1:0]  in_row;
	logic              out_free, out_load;
	logic [7:0]        attr;
	logic [15:0]       blank;
	logic [ADDR_W-1:0] pos;
	logic [7:0]        col_nx;
	logic [ROW_W:0]    row_nx;
	logic [ROW_W-1:0]  n_lines;
	logic [ADDR_W-1:0] out_offset;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign out_free = !m_tvalid_q || m_tready;
	assign attr     = {back_q, text_q};
	assign blank    = {attr, 8'd0};
	assign pos      = cell_addr(cur_row_q, cur_col_q);
	assign in_col   = (s_tdata[14:8] > COL_W'(COLS - 1)) ? COL_W'(COLS - 1) : s_tdata[14:8];
	assign in_row   = (s_tdata[19:15] > ROW_W'(ROWS - 1)) ? ROW_W'(ROWS - 1) : s_tdata[19:15];
	assign n_lines  = (arg_q > ROW_W'(ROWS)) ? ROW_W'(ROWS) : arg_q;

	// Sequencer
	always_comb begin
		logic fin;
		fin        = 1'b0;
		state_d    = state_q;
		cur_col_d  = cur_col_q;
		cur_row_d  = cur_row_q;
		src_d      = src_q;
		dst_d      = dst_q;
		end_d      = end_q;
		pend_d     = 1'b0;
		init_d     = init_q;
		scroll_d   = scroll_q;
		tab_addr_d = tab_addr_q;
		cell_d     = cell_q;
		wr_en      = 1'b0;
		wr_addr    = pos;
		wr_data    = blank;
		rd_en      = 1'b0;
		rd_addr    = cell_addr(in_row, in_col);
		col_nx     = 8'd0;
		row_nx     = '0;
		out_load   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				// Fetch the addressed cell right away on every accepted request; only a read uses it
				if (accept) begin
					rd_en   = 1'b1;
					cell_d  = 16'd0;
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				unique case (cmd_q)
					CMD_PUT: begin
						// Write the cell (not for a newline), then advance, wrap and possibly scroll
						row_nx = {1'b0, cur_row_q};
						if (char_q == CHAR_NL) begin
							row_nx = {1'b0, cur_row_q} + 1'b1;
						end else begin
							wr_en   = 1'b1;
							wr_data = {attr, (char_q == CHAR_TAB) ? 8'd0 : char_q};
							col_nx  = {1'b0, cur_col_q} + ((char_q == CHAR_TAB) ? 8'd2 : 8'd1);
							if (col_nx >= 8'(COLS)) begin
								col_nx = 8'd0;
								row_nx = {1'b0, cur_row_q} + 1'b1;
							end
						end
						scroll_d = 1'b0;
						if (row_nx >= (ROW_W + 1)'(ROWS)) begin
							row_nx   = (ROW_W + 1)'(ROWS - 1);
							col_nx   = 8'd0;
							scroll_d = 1'b1;
						end
						cur_col_d  = col_nx[COL_W-1:0];
						cur_row_d  = row_nx[ROW_W-1:0];
						tab_addr_d = pos + 1'b1;
						if (char_q == CHAR_TAB && pos != LAST_ADDR) begin
							state_d = ST_TAB2;
						end else if (scroll_d) begin
							src_d   = ADDR_W'(COLS);
							dst_d   = '0;
							end_d   = LAST_ADDR;
							state_d = ST_SWEEP;
						end else begin
							fin = 1'b1;
						end
					end
					CMD_SETCUR: begin
						cur_col_d = col_q;
						cur_row_d = row_q;
						fin       = 1'b1;
					end
					CMD_CLRSCR: begin
						src_d   = END_ADDR;
						dst_d   = '0;
						end_d   = LAST_ADDR;
						state_d = ST_SWEEP;
					end
					CMD_CLRLN: begin
						if (arg_q < ROW_W'(ROWS)) begin
							src_d   = END_ADDR;
							dst_d   = cell_addr(arg_q, '0);
							end_d   = cell_addr(arg_q, COL_W'(COLS - 1));
							state_d = ST_SWEEP;
						end else begin
							fin = 1'b1;
						end
					end
					CMD_SCROLL: begin
						if (arg_q != '0) begin
							src_d   = cell_addr(n_lines, '0);
							dst_d   = '0;
							end_d   = LAST_ADDR;
							state_d = ST_SWEEP;
						end else begin
							fin = 1'b1;
						end
					end
					CMD_READ: begin
						cell_d = rd_q;
						fin    = 1'b1;
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
			ST_TAB2: begin
				// Second blank of a tab, then scroll if the cursor ran off the bottom
				wr_en   = 1'b1;
				wr_addr = tab_addr_q;
				if (scroll_q) begin
					src_d   = ADDR_W'(COLS);
					dst_d   = '0;
					end_d   = LAST_ADDR;
					state_d = ST_SWEEP;
				end else begin
					fin = 1'b1;
				end
			end
			ST_SWEEP: begin
				// Read sources ahead, write each one in the next cycle, blank once sources run out
				rd_addr = src_q;
				if (src_q != END_ADDR) begin
					rd_en  = 1'b1;
					pend_d = 1'b1;
					src_d  = src_q + 1'b1;
				end
				wr_addr = dst_q;
				wr_data = pend_s1 ? rd_q : (init_q ? RESET_CELL : blank);
				if (pend_s1 || src_q == END_ADDR) begin
					wr_en = 1'b1;
					dst_d = dst_q + 1'b1;
					if (dst_q == end_q) begin
						if (init_q) begin
							init_d  = 1'b0;
							state_d = ST_IDLE;
						end else begin
							fin = 1'b1;
						end
					end
				end
			end
			ST_DONE: begin
				// Hold the result until the output register frees up
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Finish: hand the result over directly when the output register is free
		if (fin) begin
			if (out_free) begin
				out_load = 1'b1;
				state_d  = ST_IDLE;
			end else begin
				state_d = ST_DONE;
			end
		end
	end

	assign out_offset = cell_addr(cur_row_d, cur_col_d);

	// Cell RAM ports
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_SWEEP;
			init_q     <= 1'b1;
			src_q      <= END_ADDR;
			dst_q      <= '0;
			end_q      <= LAST_ADDR;
			pend_s1    <= 1'b0;
			scroll_q   <= 1'b0;
			cur_col_q  <= '0;
			cur_row_q  <= '0;
			text_q     <= 4'hF;
			back_q     <= 4'h0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			init_q   <= init_d;
			src_q    <= src_d;
			dst_q    <= dst_d;
			end_q    <= end_d;
			pend_s1  <= pend_d;
			scroll_q <= scroll_d;
			cur_col_q <= cur_col_d;
			cur_row_q <= cur_row_d;
			if (cfg_we) begin
				if (cfg_index == CFG_TEXT_COLOR) begin
					text_q <= cfg_data;
				end else begin
					back_q <= cfg_data;
				end
			end
			if (out_load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		tab_addr_q <= tab_addr_d;
		cell_q     <= cell_d;
		if (accept) begin
			cmd_q  <= cmd_t'(s_tuser);
			char_q <= s_tdata[7:0];
			col_q  <= in_col;
			row_q  <= in_row;
			arg_q  <= s_tdata[24:20];
		end
		if (out_load) begin
			m_tdata_q <= {1'b0, cell_d[15:8], cell_d[7:0], out_offset, cur_row_d, cur_col_d};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// Writes stay inside the screen
	a_wr_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (wr_addr < END_ADDR))
		else $error("cell write outside the screen");

	// No RAM write while waiting for a request
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_en)
		else $error("cell write while idle");

	// Cursor always on the screen
	a_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(cur_col_q < COL_W'(COLS)) && (cur_row_q < ROW_W'(ROWS)))
		else $error("cursor off the screen");

	// A pending copy write always follows a sweep read
	a_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && pend_s1) |-> $past(rd_en))
		else $error("copy write without a preceding read");

	// An accepted request always enters execution next
	a_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("accepted request not executed");

endmodule

@@ sim/testbench.sv @@
// Testbench for text_console_engine: directed and random requests, scoreboard against a
// cycle-free console predictor. Depends on tce_pkg and text_console_engine (hdl/).
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import tce_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int SETTLE_CYCLES  = 10;

	// One predicted result
	typedef struct {
		logic [6:0]  cursor_col;
		logic [4:0]  cursor_row;
		logic [10:0] cursor_offset;
		logic [7:0]  cell_char;
		logic [7:0]  cell_attr;
	} console_report_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // char_code[7:0], col[14:8], row[19:15], line_arg[24:20]
	logic [2:0]  s_tuser;   // command[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;   // cursor_col[6:0], cursor_row[11:7], cursor_offset[22:12],
	                        // cell_char[30:23], cell_attr[38:31]
	logic        cfg_we;
	logic        cfg_index;
	logic [3:0]  cfg_data;

	// Predictor state: cell store, cursor and colors
	logic [15:0] cell_store [NCELLS];
	int          at_col;
	int          at_row;
	logic [3:0]  fg_nibble;
	logic [3:0]  bg_nibble;

	console_report_t pending_reports [$];
	int  mismatch_count  = 0;
	int  requests_sent   = 0;
	int  reports_checked = 0;
	int  color_settings  = 0;
	int  quiet_cycles    = 0;
	int  ready_hold      = 0;
	bit  idle_en         = 1'b1;

	text_console_engine dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic logic [15:0] blank_cell();
		return {bg_nibble, fg_nibble, 8'h00};
	endfunction

	// Move the store up by n lines and blank the lines that come in at the bottom
	function automatic void scroll_lines(int n);
		int i;
		if (n == 0)
			return;
		if (n > ROWS)
			n = ROWS;
		for (i = 0; i < (ROWS - n) * COLS; i++)
			cell_store[i] = cell_store[i + n * COLS];
		for (i = (ROWS - n) * COLS; i < NCELLS; i++)
			cell_store[i] = blank_cell();
	endfunction

	function automatic console_report_t predict_report(cmd_t cmd, logic [7:0] ch,
		logic [6:0] col, logic [4:0] row, logic [4:0] arg);
		int c;
		int r;
		int pos;
		int i;
		console_report_t rep;
		c = (col > COLS - 1) ? COLS - 1 : int'(col);
		r = (row > ROWS - 1) ? ROWS - 1 : int'(row);
		rep.cell_char = '0;
		rep.cell_attr = '0;
		case (cmd)
			CMD_PUT: begin
				pos = at_row * COLS + at_col;
				if (ch == CHAR_NL) begin
					at_row++;
					at_col = 0;
				end else if (ch == CHAR_TAB) begin
					// second blank is dropped past the last cell
					cell_store[pos] = blank_cell();
					if (pos + 1 < NCELLS)
						cell_store[pos + 1] = blank_cell();
					at_col += 2;
				end else begin
					cell_store[pos] = blank_cell() | {8'h00, ch};
					at_col++;
				end
				if (at_col >= COLS) begin
					at_row++;
					at_col = 0;
				end
				if (at_row >= ROWS) begin
					at_row = ROWS - 1;
					at_col = 0;
					scroll_lines(1);
				end
			end
			CMD_SETCUR: begin
				at_col = c;
				at_row = r;
			end
			CMD_CLRSCR: begin
				for (i = 0; i < NCELLS; i++)
					cell_store[i] = blank_cell();
			end
			CMD_CLRLN: begin
				if (arg < ROWS)
					for (i = 0; i < COLS; i++)
						cell_store[arg * COLS + i] = blank_cell();
			end
			CMD_SCROLL: scroll_lines(int'(arg));
			CMD_READ: begin
				rep.cell_char = cell_store[r * COLS + c][7:0];
				rep.cell_attr = cell_store[r * COLS + c][15:8];
			end
			default: ;
		endcase
		rep.cursor_col    = 7'(at_col);
		rep.cursor_row    = 5'(at_row);
		rep.cursor_offset = 11'(at_row * COLS + at_col);
		return rep;
	endfunction

	// ------------------------------------------------------------------
	// Request driver, result checker, ready stalls, watchdog
	// ------------------------------------------------------------------

	// Present one request, hold it until accepted, then queue its expected result
	task automatic send_request(cmd_t cmd, logic [7:0] ch, logic [6:0] col,
		logic [4:0] row, logic [4:0] arg);
		@(negedge clk);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {7'b0, arg, row, col, ch};
		do
			@(posedge clk);
		while (!s_tready);
		pending_reports.push_back(predict_report(cmd, ch, col, row, arg));
		requests_sent++;
	endtask

	// Drop valid and wait until every expected result has come back
	task automatic wait_drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending_reports.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both color registers while the block is idle
	task automatic set_colors(logic [3:0] fg, logic [3:0] bg);
		wait_drain();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_TEXT_COLOR;
		cfg_data  <= fg;
		@(negedge clk);
		cfg_index <= CFG_BACK_COLOR;
		cfg_data  <= bg;
		@(negedge clk);
		cfg_we    <= 1'b0;
		fg_nibble = fg;
		bg_nibble = bg;
		color_settings++;
	endtask

	// Compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		console_report_t exp_rep;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_reports.size() == 0) begin
				$error("unexpected result: m_tdata=%h", m_tdata);
				mismatch_count++;
			end else begin
				exp_rep = pending_reports.pop_front();
				reports_checked++;
				if (m_tdata[6:0] !== exp_rep.cursor_col) begin
					$error("cursor_col: expected %0d, got %0d", exp_rep.cursor_col,
						m_tdata[6:0]);
					mismatch_count++;
				end
				if (m_tdata[11:7] !== exp_rep.cursor_row) begin
					$error("cursor_row: expected %0d, got %0d", exp_rep.cursor_row,
						m_tdata[11:7]);
					mismatch_count++;
				end
				if (m_tdata[22:12] !== exp_rep.cursor_offset) begin
					$error("cursor_offset: expected %0d, got %0d", exp_rep.cursor_offset,
						m_tdata[22:12]);
					mismatch_count++;
				end
				if (m_tdata[30:23] !== exp_rep.cell_char) begin
					$error("cell_char: expected %h, got %h", exp_rep.cell_char,
						m_tdata[30:23]);
					mismatch_count++;
				end
				if (m_tdata[38:31] !== exp_rep.cell_attr) begin
					$error("cell_attr: expected %h, got %h", exp_rep.cell_attr,
						m_tdata[38:31]);
					mismatch_count++;
				end
			end
		end
	end

	// Stall the result side in random bursts while idle_en is set; otherwise keep it ready
	always @(negedge clk) begin
		if (!idle_en) begin
			m_tready <= 1'b1;
		end else if (ready_hold > 0) begin
			ready_hold <= ready_hold - 1;
			m_tready   <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			ready_hold <= int'($urandom_range(0, 5));
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// End the run when nothing moves for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", quiet_cycles);
			$display("testbench: done, errors");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------

	// Cells hold white on black after the clearing pass; out-of-range read clamps
	task automatic test_reset_contents();
		send_request(CMD_READ, 8'h00, 7'd127, 5'd31, 5'd0);
	endtask

	// Plain chars, line wrap, newline, tab across a row end and at the last cell
	task automatic test_put_char();
		send_request(CMD_SETCUR, 8'h00, 7'd78, 5'd0, 5'd0);
		send_request(CMD_PUT, 8'h41, 7'd0, 5'd0, 5'd0);
		send_request(CMD_PUT, 8'hFF, 7'd0, 5'd0, 5'd0);
		send_request(CMD_PUT, 8'h00, 7'd0, 5'd0, 5'd0);
		send_request(CMD_READ, 8'h00, 7'd79, 5'd0, 5'd0);
		send_request(CMD_PUT, CHAR_NL, 7'd0, 5'd0, 5'd0);
		send_request(CMD_SETCUR, 8'h00, 7'd79, 5'd3, 5'd0);
		send_request(CMD_PUT, CHAR_TAB, 7'd0, 5'd0, 5'd0);
		send_request(CMD_READ, 8'h00, 7'd0, 5'd4, 5'd0);
		send_request(CMD_SETCUR, 8'h00, 7'd79, 5'd24, 5'd0);
		send_request(CMD_PUT, CHAR_TAB, 7'd0, 5'd0, 5'd0);
		send_request(CMD_READ, 8'h00, 7'd79, 5'd23, 5'd0);
		send_request(CMD_SETCUR, 8'h00, 7'd79, 5'd24, 5'd0);
		send_request(CMD_PUT, 8'h5A, 7'd0, 5'd0, 5'd0);
		send_request(CMD_PUT, CHAR_NL, 7'd0, 5'd0, 5'd0);
	endtask

	// Set cursor beyond the screen saturates to the bottom-right cell
	task automatic test_cursor_clamp();
		send_request(CMD_SETCUR, 8'hFF, 7'd127, 5'd31, 5'd31);
	endtask

	// Clear line in and out of range, scroll by none, one and too many, clear screen, unused codes
	task automatic test_clear_and_scroll();
		send_request(CMD_CLRLN, 8'h00, 7'd0, 5'd0, 5'd0);
		send_request(CMD_CLRLN, 8'h00, 7'd0, 5'd0, 5'd25);
		send_request(CMD_CLRLN, 8'h00, 7'd0, 5'd0, 5'd31);
		send_request(CMD_SCROLL, 8'h00, 7'd0, 5'd0, 5'd0);
		send_request(CMD_SCROLL, 8'h00, 7'd0, 5'd0, 5'd1);
		send_request(CMD_SCROLL, 8'h00, 7'd0, 5'd0, 5'd31);
		send_request(CMD_CLRSCR, 8'hFF, 7'd127, 5'd31, 5'd31);
		send_request(CMD_NOP6, 8'hFF, 7'd127, 5'd31, 5'd31);
		send_request(CMD_NOP7, 8'h00, 7'd0, 5'd0, 5'd0);
	endtask

	// Random text with cursor moves, read-backs near the cursor, clears and scrolls
	task automatic test_random(int count, logic [3:0] fg, logic [3:0] bg, bit with_idle);
		int k;
		int pick;
		int off;
		cmd_t cmd;
		logic [7:0] ch;
		logic [6:0] col;
		logic [4:0] row;
		logic [4:0] arg;
		set_colors(fg, bg);
		idle_en = with_idle;
		for (k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			ch   = 8'($urandom_range(0, 255));
			col  = 7'($urandom_range(0, 127));
			row  = 5'($urandom_range(0, 31));
			arg  = 5'($urandom_range(0, 31));
			if (pick < 45) begin
				cmd = CMD_PUT;
				case ($urandom_range(0, 19))
					0, 1: ch = CHAR_NL;
					2:    ch = CHAR_TAB;
					default: ;
				endcase
			end else if (pick < 55) begin
				cmd = CMD_SETCUR;
				if ($urandom_range(0, 2) == 0) begin
					// aim at the bottom row end so text runs off the screen
					row = 5'(ROWS - 1);
					col = 7'($urandom_range(COLS - 8, COLS - 1));
				end else if ($urandom_range(0, 1) == 0) begin
					row = 5'($urandom_range(0, ROWS - 1));
					col = 7'($urandom_range(0, COLS - 1));
				end
			end else if (pick < 82) begin
				cmd = CMD_READ;
				if ($urandom_range(0, 1) == 0) begin
					// read back what was just written
					off = at_row * COLS + at_col - $urandom_range(1, 4);
					if (off < 0)
						off = 0;
					row = 5'(off / COLS);
					col = 7'(off % COLS);
				end
			end else if (pick < 85) begin
				cmd = CMD_CLRSCR;
			end else if (pick < 89) begin
				cmd = CMD_CLRLN;
			end else if (pick < 94) begin
				cmd = CMD_SCROLL;
				if ($urandom_range(0, 1) == 0)
					arg = 5'($urandom_range(0, 3));
			end else begin
				cmd = ($urandom_range(0, 1) == 0) ? CMD_NOP6 : CMD_NOP7;
			end
			send_request(cmd, ch, col, row, arg);
		end
	endtask

	// ------------------------------------------------------------------
	// Run
	// ------------------------------------------------------------------
	initial begin
		int i;
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = CMD_PUT;
		cfg_we    = 1'b0;
		cfg_index = CFG_TEXT_COLOR;
		cfg_data  = '0;
		for (i = 0; i < NCELLS; i++)
			cell_store[i] = RESET_CELL;
		at_col    = 0;
		at_row    = 0;
		fg_nibble = 4'd15;
		bg_nibble = 4'd0;

		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_reset_contents();
		test_put_char();
		test_cursor_clamp();
		test_clear_and_scroll();

		test_random(185, 4'd0, 4'd0, 1'b1);
		test_random(185, 4'd15, 4'd15, 1'b1);
		test_random(185, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b1);
		test_random(185, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);
		test_random(185, 4'd15, 4'd0, 1'b1);
		test_random(185, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), 1'b0);

		wait_drain();
		repeat (40) @(posedge clk);

		$display("summary: %0d requests, %0d results checked, %0d color settings",
			requests_sent, reports_checked, color_settings);
		$display("summary: %0d field mismatches or stray results", mismatch_count);
		if (mismatch_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

@@ files.f @@
hdl/tce_pkg.sv
hdl/text_console_engine.sv
sim/testbench.sv
